// ----- src/utf8_filename_validator_unit_assert.svh -----
// assertion macros shared by the validator modules
`ifndef UTF8_FILENAME_VALIDATOR_UNIT_ASSERT_SVH
`define UTF8_FILENAME_VALIDATOR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define UFV_ASSERT_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");
`define UFV_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define UFV_ASSERT_IMPLY(lbl, ante, cons)
`define UFV_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- src/utf8fv_pkg.sv -----
package utf8fv_pkg;

   localparam logic [7:0]  LimitReset = 8'd255;
   localparam logic [8:0]  CountMax   = 9'd511;
   localparam logic [20:0] CpMax      = 21'h10FFFF;

   typedef enum logic [1:0] {
      DOT_START,
      DOT_ONE,
      DOT_TWO,
      DOT_OTHER
   } dot_type;

   // smallest legal code point for the sequence being decoded
   typedef enum logic [1:0] {
      CLS_NONE,
      CLS_TWO,
      CLS_THREE,
      CLS_FOUR
   } cls_type;

   typedef struct packed {
      logic [8:0]  byte_count;
      logic [1:0]  pend;
      logic [20:0] accum;
      cls_type     min_class;
      logic        seen_bad;
      dot_type     dot;
   } state_type;

   function automatic logic cp_bad(input logic [20:0] cp, input cls_type cls);
      logic [20:0] minimum;
      unique case (cls)
         CLS_NONE:  minimum = 21'h0;
         CLS_TWO:   minimum = 21'h80;
         CLS_THREE: minimum = 21'h800;
         CLS_FOUR:  minimum = 21'h10000;
         default:   minimum = 21'h0;
      endcase
      return (cp < minimum) || (cp > CpMax)
          || (cp >= 21'hD800 && cp <= 21'hDFFF)
          || (cp < 21'h20)
          || (cp >= 21'h7F && cp <= 21'h9F)
          || (cp == 21'h2F) || (cp == 21'h5C) || (cp == 21'h3A);
   endfunction

endpackage

// ----- src/utf8_filename_validator_unit.sv -----
// a terminating zero byte is held in the input register, then its verdict in the result
//   register, which drives rsp_valid; other bytes give no result
// throughput: one byte per cycle; only a terminator meeting a full, stalled result
//   register holds the input register, and then req_stall rises
// reset: synchronous, clears decode state and result valid, limit back to 255
module utf8_filename_validator_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_name_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_name_ok,
   output logic       rsp_over_length,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);
   import utf8fv_pkg::*;

   `include "utf8_filename_validator_unit_assert.svh"

   logic       in_vld_ff, in_vld_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic [7:0] limit_ff, limit_in;
   state_type  state_ff, state_in, step_state;
   logic       step_ok, step_over;
   logic       is_term, out_free, advance;

   assign is_term   = (in_byte_ff == 8'd0);
   assign advance   = in_vld_ff && (!is_term || out_free);
   assign req_stall = in_vld_ff && !advance;

   always_comb begin
      in_vld_in  = in_vld_ff;
      in_byte_in = in_byte_ff;
      if (!req_stall) begin
         in_vld_in  = req_valid;
         in_byte_in = req_name_byte;
      end
      state_in = advance ? step_state : state_ff;
      limit_in = csr_wr_en ? csr_wr_data : limit_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         state_ff  <= '0;
         limit_ff  <= LimitReset;
      end else begin
         in_vld_ff <= in_vld_in;
         state_ff  <= state_in;
         limit_ff  <= limit_in;
      end
      in_byte_ff <= in_byte_in;
   end

   utf8fv_step u_step (
      .cur_state   (state_ff),
      .name_byte   (in_byte_ff),
      .limit       (limit_ff),
      .nxt_state   (step_state),
      .name_ok     (step_ok),
      .over_length (step_over)
   );

   utf8fv_rsp_buf u_rsp_buf (
      .clock           (clock),
      .reset           (reset),
      .load            (advance && is_term),
      .load_ok         (step_ok),
      .load_over       (step_over),
      .free            (out_free),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_name_ok     (rsp_name_ok),
      .rsp_over_length (rsp_over_length)
   );

   `UFV_ASSERT_IMPLY(a_rsp_from_term, $rose(rsp_valid), $past(in_vld_ff && is_term))
   `UFV_ASSERT_IMPLY(a_pend_has_class, state_ff.pend != 2'd0, state_ff.min_class != CLS_NONE)
   `UFV_ASSERT_IMPLY(a_empty_is_clear, state_ff.byte_count == 9'd0,
                     state_ff.pend == 2'd0 && state_ff.dot == DOT_START)
   `UFV_ASSERT_NEXT(a_held_byte_stays, in_vld_ff && !advance, in_vld_ff)

endmodule

// ----- src/utf8fv_step.sv -----
module utf8fv_step (
   input  utf8fv_pkg::state_type cur_state,
   input  logic [7:0]            name_byte,
   input  logic [7:0]            limit,
   output utf8fv_pkg::state_type nxt_state,
   output logic                  name_ok,
   output logic                  over_length
);
   import utf8fv_pkg::*;

   logic [20:0] acc_shift;

   assign acc_shift = {cur_state.accum[14:0], name_byte[5:0]};

   always_comb begin
      nxt_state   = cur_state;
      over_length = cur_state.byte_count > {1'b0, limit};
      name_ok     = 1'b0;
      if (name_byte == 8'd0) begin
         name_ok = (cur_state.byte_count != 9'd0) && !over_length
                && (cur_state.dot != DOT_ONE) && (cur_state.dot != DOT_TWO)
                && !cur_state.seen_bad && (cur_state.pend == 2'd0);
         nxt_state = '0;
      end else begin
         if (cur_state.byte_count != CountMax) begin
            nxt_state.byte_count = cur_state.byte_count + 9'd1;
         end
         if (cur_state.dot == DOT_START && name_byte == 8'h2E) begin
            nxt_state.dot = DOT_ONE;
         end else if (cur_state.dot == DOT_ONE && name_byte == 8'h2E) begin
            nxt_state.dot = DOT_TWO;
         end else begin
            nxt_state.dot = DOT_OTHER;
         end
         if (cur_state.pend == 2'd0) begin
            if (!name_byte[7]) begin
               nxt_state.accum     = {13'd0, name_byte};
               nxt_state.min_class = CLS_NONE;
               if (cp_bad({13'd0, name_byte}, CLS_NONE)) begin
                  nxt_state.seen_bad = 1'b1;
               end
            end else if (name_byte[7:5] == 3'b110) begin
               nxt_state.accum     = {16'd0, name_byte[4:0]};
               nxt_state.min_class = CLS_TWO;
               nxt_state.pend      = 2'd1;
               // 0xc0 and 0xc1 can only give overlong forms
               if (name_byte[4:1] == 4'd0) begin
                  nxt_state.seen_bad = 1'b1;
               end
            end else if (name_byte[7:4] == 4'b1110) begin
               nxt_state.accum     = {17'd0, name_byte[3:0]};
               nxt_state.min_class = CLS_THREE;
               nxt_state.pend      = 2'd2;
            end else if (name_byte[7:3] == 5'b11110) begin
               nxt_state.accum     = {18'd0, name_byte[2:0]};
               nxt_state.min_class = CLS_FOUR;
               nxt_state.pend      = 2'd3;
            end else begin
               nxt_state.seen_bad = 1'b1;
            end
         end else begin
            if (name_byte[7:6] != 2'b10) begin
               nxt_state.seen_bad = 1'b1;
               nxt_state.pend     = 2'd0;
            end else begin
               nxt_state.accum = acc_shift;
               nxt_state.pend  = cur_state.pend - 2'd1;
               if (cur_state.pend == 2'd1 && cp_bad(acc_shift, cur_state.min_class)) begin
                  nxt_state.seen_bad = 1'b1;
               end
            end
         end
      end
   end

endmodule

// ----- src/utf8fv_rsp_buf.sv -----
`include "utf8_filename_validator_unit_assert.svh"

module utf8fv_rsp_buf (
   input  logic clock,
   input  logic reset,
   input  logic load,
   input  logic load_ok,
   input  logic load_over,
   output logic free,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic rsp_name_ok,
   output logic rsp_over_length
);

   logic vld_ff, vld_in;
   logic ok_ff, ok_in;
   logic over_ff, over_in;

   // slot can take a new verdict when empty or being drained this cycle
   assign free = !vld_ff || !rsp_stall;

   always_comb begin
      vld_in  = vld_ff;
      ok_in   = ok_ff;
      over_in = over_ff;
      if (free) begin
         vld_in  = load;
         ok_in   = load_ok;
         over_in = load_over;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      ok_ff   <= ok_in;
      over_ff <= over_in;
   end

   assign rsp_valid       = vld_ff;
   assign rsp_name_ok     = ok_ff;
   assign rsp_over_length = over_ff;

   `UFV_ASSERT_IMPLY(a_over_rejects, vld_ff && over_ff, !ok_ff)
   `UFV_ASSERT_NEXT(a_load_shows, load && free, vld_ff)
   `UFV_ASSERT_NEXT(a_stall_holds, vld_ff && rsp_stall,
                    vld_ff && $stable(ok_ff) && $stable(over_ff))

endmodule

// ----- verif/utf8_filename_validator_unit_tb.sv -----
module utf8_filename_validator_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import utf8fv_pkg::*;

   localparam logic [7:0] Terminator = 8'h00;
   localparam logic [7:0] DotByte    = 8'h2E;
   localparam int         CycleLimit = 400000;
   localparam int         Settle     = 4;

   typedef struct packed {
      logic ok;
      logic over;
   } verdict_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_name_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_name_ok;
   logic       rsp_over_length;
   logic       csr_wr_en = 1'b0;
   logic [7:0] csr_wr_data = 8'h00;

   // predicted decoder state
   logic [7:0]  limit_m;
   logic [8:0]  count_m;
   logic [1:0]  pend_m;
   logic [20:0] accum_m;
   cls_type     cls_m;
   logic        bad_m;
   dot_type     dot_m;

   verdict_type verdicts_due[$];
   verdict_type verdict_now;
   logic [7:0]  name_buf[$];
   int          idle_pct = 0;
   int          stall_pct = 0;
   int          bytes_sent = 0;
   int          error_count = 0;
   int          cycle_count = 0;

   utf8_filename_validator_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_name_byte   (req_name_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_name_ok     (rsp_name_ok),
      .rsp_over_length (rsp_over_length),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("utf8_filename_validator_unit_tb failed");
         $finish;
      end
   end

   function automatic logic char_rejected(input logic [20:0] cp, input cls_type cls);
      logic [20:0] floor_cp;
      case (cls)
         CLS_TWO:   floor_cp = 21'h80;
         CLS_THREE: floor_cp = 21'h800;
         CLS_FOUR:  floor_cp = 21'h10000;
         default:   floor_cp = 21'h0;
      endcase
      if (cp < floor_cp || cp > 21'h10FFFF) return 1'b1;
      if (cp >= 21'hD800 && cp <= 21'hDFFF) return 1'b1;
      if (cp < 21'h20 || (cp >= 21'h7F && cp <= 21'h9F)) return 1'b1;
      return cp == 21'h2F || cp == 21'h5C || cp == 21'h3A;
   endfunction

   task automatic clear_decoder();
      count_m = '0;
      pend_m  = '0;
      accum_m = '0;
      cls_m   = CLS_NONE;
      bad_m   = 1'b0;
      dot_m   = DOT_START;
   endtask

   // advance the predicted state by one accepted byte
   task automatic absorb_byte(input logic [7:0] b);
      verdict_type v;
      if (b == Terminator) begin
         v.over = count_m > {1'b0, limit_m};
         v.ok   = count_m != 0 && !v.over && dot_m != DOT_ONE && dot_m != DOT_TWO
                  && !bad_m && pend_m == 0;
         verdicts_due.push_back(v);
         clear_decoder();
      end else begin
         if (count_m != CountMax) count_m = count_m + 9'd1;
         if (dot_m == DOT_START && b == DotByte) dot_m = DOT_ONE;
         else if (dot_m == DOT_ONE && b == DotByte) dot_m = DOT_TWO;
         else dot_m = DOT_OTHER;
         if (pend_m == 0) begin
            if (!b[7]) begin
               accum_m = {13'b0, b};
               cls_m   = CLS_NONE;
               if (char_rejected(accum_m, CLS_NONE)) bad_m = 1'b1;
            end else if (b[7:5] == 3'b110) begin
               accum_m = {16'b0, b[4:0]};
               cls_m   = CLS_TWO;
               pend_m  = 2'd1;
               // C0 and C1 can only start an overlong form
               if (b[4:1] == 4'b0) bad_m = 1'b1;
            end else if (b[7:4] == 4'b1110) begin
               accum_m = {17'b0, b[3:0]};
               cls_m   = CLS_THREE;
               pend_m  = 2'd2;
            end else if (b[7:3] == 5'b11110) begin
               accum_m = {18'b0, b[2:0]};
               cls_m   = CLS_FOUR;
               pend_m  = 2'd3;
            end else begin
               bad_m = 1'b1;
            end
         end else if (b[7:6] != 2'b10) begin
            bad_m  = 1'b1;
            pend_m = 2'd0;
         end else begin
            accum_m = {accum_m[14:0], b[5:0]};
            pend_m  = pend_m - 2'd1;
            if (pend_m == 0 && char_rejected(accum_m, cls_m)) bad_m = 1'b1;
         end
      end
   endtask

   task automatic note_mismatch(input string field, input logic want, input logic got);
      error_count++;
      if (error_count <= 10)
         $display("%0t: %s mismatch, expected %0b, got %0b", $realtime, field, want, got);
   endtask

   // receiver: random stall and verdict check
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= int'($urandom_range(99)) < stall_pct;
         if (rsp_valid && !rsp_stall) begin
            if (verdicts_due.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("%0t: verdict with none pending, name_ok %0b over_length %0b",
                           $realtime, rsp_name_ok, rsp_over_length);
            end else begin
               verdict_now = verdicts_due.pop_front();
               if (rsp_name_ok !== verdict_now.ok)
                  note_mismatch("name_ok", verdict_now.ok, rsp_name_ok);
               if (rsp_over_length !== verdict_now.over)
                  note_mismatch("over_length", verdict_now.over, rsp_over_length);
            end
         end
      end
   end

   // one byte transfer; valid stays high between back-to-back bytes
   task automatic send_byte(input logic [7:0] b);
      if (int'($urandom_range(99)) < idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while (int'($urandom_range(99)) < idle_pct);
      end
      req_valid     <= 1'b1;
      req_name_byte <= b;
      do @(posedge clock); while (req_stall);
      absorb_byte(b);
      bytes_sent++;
   endtask

   task automatic send_name();
      foreach (name_buf[i]) send_byte(name_buf[i]);
      send_byte(Terminator);
   endtask

   task automatic send_letters(input int n);
      name_buf.delete();
      repeat (n) name_buf.push_back(8'($urandom_range(8'h41, 8'h5A)));
      send_name();
   endtask

   // drop valid and let every pending verdict drain
   task automatic settle();
      req_valid <= 1'b0;
      while (verdicts_due.size() != 0) @(posedge clock);
      repeat (Settle) @(posedge clock);
   endtask

   task automatic set_name_limit(input logic [7:0] value);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      limit_m = value;
   endtask

   task automatic put_code_point(input logic [20:0] cp);
      if (cp < 21'h80) begin
         name_buf.push_back(cp[7:0]);
      end else if (cp < 21'h800) begin
         name_buf.push_back({3'b110, cp[10:6]});
         name_buf.push_back({2'b10, cp[5:0]});
      end else if (cp < 21'h10000) begin
         name_buf.push_back({4'b1110, cp[15:12]});
         name_buf.push_back({2'b10, cp[11:6]});
         name_buf.push_back({2'b10, cp[5:0]});
      end else begin
         name_buf.push_back({5'b11110, cp[20:18]});
         name_buf.push_back({2'b10, cp[17:12]});
         name_buf.push_back({2'b10, cp[11:6]});
         name_buf.push_back({2'b10, cp[5:0]});
      end
   endtask

   function automatic logic [20:0] random_code_point();
      case ($urandom_range(3))
         0:       return 21'($urandom_range(8'h20, 8'h7E));
         1:       return 21'($urandom_range(21'h80, 21'h7FF));
         2:       return 21'($urandom_range(21'h800, 21'hFFFF));
         default: return 21'($urandom_range(21'h10000, 21'h10FFFF));
      endcase
   endfunction

   // mostly well-formed names, some dot names, empties, names near a small limit and raw byte noise
   task automatic build_random_name();
      int pick;
      name_buf.delete();
      pick = $urandom_range(99);
      if (pick < 6) begin
         repeat ($urandom_range(1, 3)) name_buf.push_back(DotByte);
      end else if (pick < 10) begin
         // empty name
      end else if (pick < 20 && limit_m <= 8'd32) begin
         repeat ($urandom_range(int'(limit_m) + 2, int'(limit_m) - 1))
            put_code_point(random_code_point());
      end else if (pick < 85) begin
         repeat ($urandom_range(1, 8)) begin
            if ($urandom_range(9) == 0) name_buf.push_back(8'($urandom_range(1, 255)));
            else put_code_point(random_code_point());
         end
      end else begin
         repeat ($urandom_range(1, 8)) name_buf.push_back(8'($urandom_range(1, 255)));
      end
   endtask

   task automatic test_special_names();
      name_buf.delete();
      send_name();
      name_buf = '{DotByte};
      send_name();
      name_buf = '{DotByte, DotByte};
      send_name();
      name_buf = '{8'h61, 8'h2F};
      send_name();
      // overlong two-byte lead
      name_buf = '{8'hC0, 8'h80};
      send_name();
      // terminator inside a sequence
      name_buf = '{8'hE2, 8'h82};
      send_name();
      // bad continuation byte, which ends the sequence without being decoded itself
      name_buf = '{8'hC3, 8'h41};
      send_name();
      name_buf = '{8'hF4, 8'h90, 8'h80, 8'h80};
      send_name();
      name_buf = '{8'hED, 8'hA0, 8'h80};
      send_name();
      name_buf = '{8'hF0, 8'h90, 8'h80, 8'h80};
      send_name();
      name_buf = '{8'hFF, 8'h01};
      send_name();
   endtask

   task automatic test_length_limits();
      idle_pct  = 0;
      stall_pct = 0;
      set_name_limit(8'd1);
      send_letters(1);
      send_letters(2);
      set_name_limit(8'd0);
      send_letters(1);
      // names either side of a mid-range limit
      set_name_limit(8'd40);
      send_letters(40);
      send_letters(41);
   endtask

   task automatic test_random_phase(input int idle_p, input int stall_p,
                                    input logic [7:0] limit, input int budget);
      int first;
      set_name_limit(limit);
      idle_pct  = idle_p;
      stall_pct = stall_p;
      first = bytes_sent;
      while (bytes_sent - first < budget) begin
         build_random_name();
         send_name();
      end
   endtask

   initial begin
      limit_m = LimitReset;
      clear_decoder();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_special_names();
      test_length_limits();
      test_random_phase(0, 0, 8'd12, 100);
      test_random_phase(83, 0, 8'($urandom_range(1, 20)), 100);
      test_random_phase(0, 83, 8'd255, 100);
      test_random_phase(23, 23, 8'($urandom_range(1, 255)), 100);
      settle();
      if (error_count == 0) begin
         $display("utf8_filename_validator_unit_tb passed");
      end else begin
         $display("utf8_filename_validator_unit_tb failed");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+src
src/utf8fv_pkg.sv
src/utf8fv_step.sv
src/utf8fv_rsp_buf.sv
src/utf8_filename_validator_unit.sv
verif/utf8_filename_validator_unit_tb.sv
